/* rtl/barometer_compensation_defines.svh */
// Assertion macros shared by the barometer compensation checkers.
// Depends on nothing; the including scope provides clk and rst.
`ifndef BAROMETER_COMPENSATION_DEFINES_SVH
`define BAROMETER_COMPENSATION_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error(msg);

`endif

/* rtl/bc_pkg.sv */
// Types and constants for the barometer compensation block.
// Used by the front, queue, back pipeline, top level and checker.
package bc_pkg;

  localparam int unsigned RAW_W     = 24;
  localparam int unsigned CAL_W     = 16;
  localparam int unsigned DT_W      = 25;
  localparam int unsigned TEMP_W    = 19;
  localparam int unsigned PRESS_W   = 32;
  localparam int unsigned REG_IDX_W = 3;

  // Cycles from the accepting edge to the edge that takes the result.
  localparam int unsigned BC_LATENCY = 10;

  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -19'sd1500;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN  = -19'sd129070;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 19'sd133070;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } bc_reg_t;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } bc_cal_t;

  typedef struct packed {
    logic        [RAW_W-1:0] d1;
    logic signed [DT_W-1:0]  dt;
  } bc_entry_t;

  typedef struct packed {
    logic      valid;
    bc_entry_t entry;
  } bc_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bc_qstat_t;

endpackage

/* rtl/barometer_compensation.sv */
// Barometric second-order compensation. One raw pressure and temperature pair
// is taken on each cycle that start is high and busy is low; its result shows
// on done for one cycle, after the queue write and the nine-stage compensation
// pipeline, and items may follow every cycle. busy is high only during reset.
// Calibration words C1..C6 are written through the cfg port at indexes 0..5;
// other indexes are dropped. Write them only while no item is in flight.
module barometer_compensation import bc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [RAW_W-1:0]          raw_pressure,
  input  logic [RAW_W-1:0]          raw_temperature,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [REG_IDX_W-1:0]      cfg_index,
  input  logic [CAL_W-1:0]          cfg_data,
  output logic                      done,
  output logic signed [PRESS_W-1:0] pressure_pa,
  output logic signed [TEMP_W-1:0]  temperature_centi
);

  bc_cal_t   cal;
  bc_push_t  push;
  bc_qstat_t qstat;
  bc_entry_t head;
  logic      pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bc_reg_t'(cfg_index))
        REG_C1:  cal.c1 <= cfg_data;
        REG_C2:  cal.c2 <= cfg_data;
        REG_C3:  cal.c3 <= cfg_data;
        REG_C4:  cal.c4 <= cfg_data;
        REG_C5:  cal.c5 <= cfg_data;
        REG_C6:  cal.c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  bc_front u_front (
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .ref_temp        (cal.c5),
    .qstat           (qstat),
    .push            (push)
  );

  bc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  bc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cal               (cal),
    .head              (head),
    .qstat             (qstat),
    .pop               (pop),
    .done              (done),
    .pressure_pa       (pressure_pa),
    .temperature_centi (temperature_centi)
  );

endmodule

/* rtl/bc_front.sv */
// Front end: takes the start handshake, forms the temperature difference
// and pushes the item into the queue. Depends on bc_pkg.
module bc_front import bc_pkg::*; (
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [RAW_W-1:0] raw_pressure,
  input  logic [RAW_W-1:0] raw_temperature,
  input  logic [CAL_W-1:0] ref_temp,
  input  bc_qstat_t        qstat,
  output bc_push_t         push
);

  logic signed [DT_W-1:0] dt;

  // dT = D2 - C5 * 256, exact in 25 bits
  assign dt = $signed({1'b0, raw_temperature}) - $signed({1'b0, ref_temp, 8'b0});

  assign busy           = rst || qstat.full;
  assign push.valid     = start && !busy;
  assign push.entry.d1  = raw_pressure;
  assign push.entry.dt  = dt;

endmodule

/* rtl/bc_queue.sv */
// Short queue between the front end and the compensation pipeline.
// Depends on bc_pkg for the entry and status types.
module bc_queue import bc_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  bc_push_t  push,
  input  logic      pop,
  output bc_entry_t head,
  output bc_qstat_t qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bc_entry_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push.valid && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/bc_back.sv */
// Compensation pipeline: nine register stages from queue head to result.
// Depends on bc_pkg for the entry, status and calibration types.
module bc_back import bc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  bc_cal_t                  cal,
  input  bc_entry_t                head,
  input  bc_qstat_t                qstat,
  output logic                     pop,
  output logic                     done,
  output logic signed [PRESS_W-1:0] pressure_pa,
  output logic signed [TEMP_W-1:0]  temperature_centi
);

  localparam int unsigned STAGES = 9;

  logic [STAGES-1:0] valid;

  // stage 1: products of dT with C6, C4, C3
  logic signed [41:0] dt_x, c6_x, c4_x, c3_x;
  logic [RAW_W-1:0]   s1_d1;
  logic signed [41:0] s1_p6, s1_p4, s1_p3;
  // stage 2: TEMP, OFF, SENS
  logic [RAW_W-1:0]         s2_d1;
  logic signed [TEMP_W-1:0] s2_temp;
  logic signed [35:0]       s2_off;
  logic signed [34:0]       s2_sens;
  // stage 3: squares and range flags
  logic signed [19:0]       dd, ee;
  logic signed [39:0]       sq_d_full, sq_e_full;
  logic [RAW_W-1:0]         s3_d1;
  logic signed [TEMP_W-1:0] s3_temp;
  logic signed [35:0]       s3_off;
  logic signed [34:0]       s3_sens;
  logic [35:0]              s3_sqd, s3_sqe;
  logic                     s3_lt20, s3_lt15;
  // stage 4: constant multiples
  logic [38:0]              u7_full, u11_full;
  logic [RAW_W-1:0]         s4_d1;
  logic signed [TEMP_W-1:0] s4_temp;
  logic signed [35:0]       s4_off;
  logic signed [34:0]       s4_sens;
  logic [37:0]              s4_t5, s4_u7, s4_u11h;
  logic                     s4_lt20, s4_lt15;
  // stage 5: OFF2 and SENS2
  logic [RAW_W-1:0]         s5_d1;
  logic signed [TEMP_W-1:0] s5_temp;
  logic signed [35:0]       s5_off;
  logic signed [34:0]       s5_sens;
  logic [37:0]              s5_off2, s5_sens2;
  // stage 6: corrected OFF and SENS
  logic [RAW_W-1:0]         s6_d1;
  logic signed [TEMP_W-1:0] s6_temp;
  logic signed [38:0]       s6_offc, s6_sensc;
  // stage 7: split product of D1 and SENS
  logic [42:0]              d1_lo_x, lo_x;
  logic signed [44:0]       d1_hi_x, hi_x;
  logic signed [TEMP_W-1:0] s7_temp;
  logic signed [38:0]       s7_offc;
  logic [42:0]              s7_pp_lo;
  logic signed [44:0]       s7_pp_hi;
  // stage 8: recombined product
  logic signed [TEMP_W-1:0] s8_temp;
  logic signed [38:0]       s8_offc;
  logic signed [63:0]       s8_prod;
  // stage 9: pressure
  logic signed [43:0]       diff;
  logic signed [TEMP_W-1:0] s9_temp;
  logic signed [PRESS_W-1:0] s9_press;

  // the pipeline never stalls, so drain the queue whenever it has an entry
  assign pop = !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[STAGES-2:0], pop};
    end
  end

  always_comb begin
    dt_x      = 42'(head.dt);
    c6_x      = $signed({26'b0, cal.c6});
    c4_x      = $signed({26'b0, cal.c4});
    c3_x      = $signed({26'b0, cal.c3});
    dd        = $signed({s2_temp[TEMP_W-1], s2_temp}) - 20'sd2000;
    ee        = $signed({s2_temp[TEMP_W-1], s2_temp}) + 20'sd1500;
    sq_d_full = dd * dd;
    sq_e_full = ee * ee;
    u7_full   = {s3_sqe, 3'b0} - {3'b0, s3_sqe};
    u11_full  = {s3_sqe, 3'b0} + {2'b0, s3_sqe, 1'b0} + {3'b0, s3_sqe};
    d1_lo_x   = {19'b0, s6_d1};
    lo_x      = {24'b0, s6_sensc[18:0]};
    d1_hi_x   = $signed({21'b0, s6_d1});
    // upper slice carries the sign of SENS
    hi_x      = 45'($signed(s6_sensc[38:19]));
    diff      = $signed({s8_prod[63], s8_prod[63:21]}) - 44'(s8_offc);
  end

  always_ff @(posedge clk) begin
    s1_d1    <= head.d1;
    s1_p6    <= dt_x * c6_x;
    s1_p4    <= dt_x * c4_x;
    s1_p3    <= dt_x * c3_x;

    s2_d1    <= s1_d1;
    s2_temp  <= $signed(s1_p6[41:23]) + TEMP_BASE;
    s2_off   <= $signed({4'b0, cal.c2, 16'b0}) + $signed({s1_p4[41], s1_p4[41:7]});
    s2_sens  <= $signed({4'b0, cal.c1, 15'b0}) + $signed({s1_p3[41], s1_p3[41:8]});

    s3_d1    <= s2_d1;
    s3_temp  <= s2_temp;
    s3_off   <= s2_off;
    s3_sens  <= s2_sens;
    s3_sqd   <= sq_d_full[35:0];
    s3_sqe   <= sq_e_full[35:0];
    s3_lt20  <= (s2_temp < TEMP_BASE);
    s3_lt15  <= (s2_temp < TEMP_COLD);

    s4_d1    <= s3_d1;
    s4_temp  <= s3_temp;
    s4_off   <= s3_off;
    s4_sens  <= s3_sens;
    s4_t5    <= {s3_sqd, 2'b0} + {2'b0, s3_sqd};
    s4_u7    <= u7_full[37:0];
    s4_u11h  <= u11_full[38:1];
    s4_lt20  <= s3_lt20;
    s4_lt15  <= s3_lt15;

    s5_d1    <= s4_d1;
    s5_temp  <= s4_temp;
    s5_off   <= s4_off;
    s5_sens  <= s4_sens;
    s5_off2  <= (s4_lt20 ? {1'b0, s4_t5[37:1]} : 38'd0) + (s4_lt15 ? s4_u7 : 38'd0);
    s5_sens2 <= (s4_lt20 ? {2'b0, s4_t5[37:2]} : 38'd0) + (s4_lt15 ? s4_u11h : 38'd0);

    s6_d1    <= s5_d1;
    s6_temp  <= s5_temp;
    s6_offc  <= 39'(s5_off) - $signed({1'b0, s5_off2});
    s6_sensc <= 39'(s5_sens) - $signed({1'b0, s5_sens2});

    s7_temp  <= s6_temp;
    s7_offc  <= s6_offc;
    s7_pp_lo <= d1_lo_x * lo_x;
    s7_pp_hi <= d1_hi_x * hi_x;

    s8_temp  <= s7_temp;
    s8_offc  <= s7_offc;
    s8_prod  <= ($signed({{19{s7_pp_hi[44]}}, s7_pp_hi}) <<< 19) + $signed({21'b0, s7_pp_lo});

    s9_temp  <= s8_temp;
    s9_press <= $signed({{3{diff[43]}}, diff[43:15]});
  end

  assign done              = valid[STAGES-1];
  assign pressure_pa       = s9_press;
  assign temperature_centi = s9_temp;

endmodule

/* rtl/bc_checker.sv */
// Port-level checks for barometer_compensation, bound to the top level.
// Depends on bc_pkg and barometer_compensation_defines.svh.
`include "barometer_compensation_defines.svh"

module bc_checker import bc_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic signed [TEMP_W-1:0]  temperature_centi
);

  // every transfer in comes out after the fixed latency, and nothing else does
  `BC_ASSERT_IMPL(a_result_follows, start && !busy, ##BC_LATENCY done, "result missing")
  `BC_ASSERT_IMPL(a_no_extra_result, done, $past(start && !busy, BC_LATENCY), "spurious result")
  // the queue drains every cycle, so it never backs up
  `BC_ASSERT_NEXT(a_never_busy, start && !busy, !busy, "queue backed up")
  `BC_ASSERT_IMPL(a_temp_range, done,
                  temperature_centi >= TEMP_MIN && temperature_centi <= TEMP_MAX,
                  "temperature out of range")

endmodule

bind barometer_compensation bc_checker u_bc_checker (.*);

/* tb/sv/barometer_compensation_test.sv */
// Self-checking testbench for barometer_compensation: calibration programming,
// directed and random raw conversions, results compared against a local model.
// Depends on bc_pkg and the barometer_compensation RTL.
module barometer_compensation_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bc_pkg::*;

  localparam logic [REG_IDX_W-1:0] IDX_SPARE_FIRST = 3'd6;
  localparam logic [REG_IDX_W-1:0] IDX_SPARE_LAST  = 3'd7;
  localparam logic [RAW_W-1:0]     RAW_MAX         = {RAW_W{1'b1}};
  localparam logic [CAL_W-1:0]     CAL_MAX         = {CAL_W{1'b1}};
  localparam int                   REPORT_LIMIT    = 10;
  localparam int                   RANDOM_PHASES   = 10;
  localparam int                   PHASE_READINGS  = 123;

  typedef struct {
    logic [RAW_W-1:0]          d1;
    logic [RAW_W-1:0]          d2;
    logic signed [PRESS_W-1:0] pressure;
    logic signed [TEMP_W-1:0]  temp;
  } compensated_reading_t;

  class compensation_scoreboard;
    logic [CAL_W-1:0]     cal_word [6];
    compensated_reading_t expected_readings [$];
    int                   mismatches;

    function new();
      foreach (cal_word[i]) cal_word[i] = '0;
      mismatches = 0;
    endfunction

    function void write_cal(logic [REG_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
      // Indexes past C6 are dropped by the block.
      if (idx <= REG_C6) cal_word[idx] = data;
    endfunction

    function void note_input(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
      longint c1, c2, c3, c4, c5, c6;
      longint dt, off, sens, temp, off2, sens2, d, t, e, u, press;
      compensated_reading_t want;
      c1 = longint'(cal_word[REG_C1]);
      c2 = longint'(cal_word[REG_C2]);
      c3 = longint'(cal_word[REG_C3]);
      c4 = longint'(cal_word[REG_C4]);
      c5 = longint'(cal_word[REG_C5]);
      c6 = longint'(cal_word[REG_C6]);
      dt   = longint'(d2) - c5 * 256;
      off  = c2 * 65536 + ((dt * c4) >>> 7);
      sens = c1 * 32768 + ((dt * c3) >>> 8);
      temp = longint'(TEMP_BASE) + ((dt * c6) >>> 23);
      off2  = 0;
      sens2 = 0;
      if (temp < longint'(TEMP_BASE)) begin
        d = temp - longint'(TEMP_BASE);
        t = 5 * d * d;
        off2  = t >>> 1;
        sens2 = t >>> 2;
        if (temp < longint'(TEMP_COLD)) begin
          e = temp - longint'(TEMP_COLD);
          u = e * e;
          off2  += 7 * u;
          sens2 += (11 * u) >>> 1;
        end
      end
      press = (((longint'(d1) * (sens - sens2)) >>> 21) - (off - off2)) >>> 15;
      want.d1       = d1;
      want.d2       = d2;
      want.pressure = press[PRESS_W-1:0];
      want.temp     = temp[TEMP_W-1:0];
      expected_readings.push_back(want);
    endfunction

    function void check_result(logic signed [PRESS_W-1:0] pressure,
                               logic signed [TEMP_W-1:0] temp);
      compensated_reading_t want;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: pressure %0d temperature %0d", pressure, temp);
        return;
      end
      want = expected_readings.pop_front();
      if (pressure !== want.pressure || temp !== want.temp) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch d1=%0d d2=%0d: pressure %0d (expected %0d), temperature %0d (expected %0d)",
                   want.d1, want.d2, pressure, want.pressure, temp, want.temp);
      end
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [RAW_W-1:0]          raw_pressure = '0;
  logic [RAW_W-1:0]          raw_temperature = '0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [REG_IDX_W-1:0]      cfg_index = '0;
  logic [CAL_W-1:0]          cfg_data = '0;
  logic                      done;
  logic signed [PRESS_W-1:0] pressure_pa;
  logic signed [TEMP_W-1:0]  temperature_centi;

  compensation_scoreboard sb = new();

  barometer_compensation dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .raw_pressure     (raw_pressure),
    .raw_temperature  (raw_temperature),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .done             (done),
    .pressure_pa      (pressure_pa),
    .temperature_centi(temperature_centi)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(pressure_pa, temperature_centi);
  end

  // Raw D2 whose first-order temperature hits target if C6 is nonzero, clamped to 24 bits.
  function automatic logic [RAW_W-1:0] raw_temperature_for(int target);
    longint num, c6, dt, d2;
    c6 = longint'(sb.cal_word[REG_C6]);
    dt = 0;
    if (c6 != 0) begin
      num = longint'(target - TEMP_BASE) * (longint'(1) << 23);
      dt = (num >= 0) ? (num + c6 - 1) / c6 : -((-num) / c6);
    end
    d2 = longint'(sb.cal_word[REG_C5]) * 256 + dt;
    if (d2 < 0) d2 = 0;
    if (d2 > longint'(RAW_MAX)) d2 = longint'(RAW_MAX);
    return d2[RAW_W-1:0];
  endfunction

  function automatic logic [CAL_W-1:0] random_cal_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CAL_MAX;
      default: return CAL_W'($urandom());
    endcase
  endfunction

  task automatic write_cal(logic [REG_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_cal(idx, data);
  endtask

  task automatic program_cal(logic [CAL_W-1:0] c1, logic [CAL_W-1:0] c2,
                             logic [CAL_W-1:0] c3, logic [CAL_W-1:0] c4,
                             logic [CAL_W-1:0] c5, logic [CAL_W-1:0] c6);
    write_cal(REG_C1, c1);
    write_cal(REG_C2, c2);
    write_cal(REG_C3, c3);
    write_cal(REG_C4, c4);
    write_cal(REG_C5, c5);
    write_cal(REG_C6, c6);
    // A stray write past the last register must leave the words alone.
    if ($urandom_range(0, 1) == 1)
      write_cal($urandom_range(0, 1) ? IDX_SPARE_FIRST : IDX_SPARE_LAST, CAL_W'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_reading(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
    start           <= 1'b1;
    raw_pressure    <= d1;
    raw_temperature <= d2;
    do @(posedge clk); while (busy);
    sb.note_input(d1, d2);
  endtask

  task automatic pause_sender(int odds);
    if (odds != 0 && $urandom_range(1, odds) == 1) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Hold until every conversion in flight has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int                gap_odds;
    logic [RAW_W-1:0]  d1;
    logic [RAW_W-1:0]  d2;
    longint            near;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset calibration: all words zero.
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    drain();

    write_cal(IDX_SPARE_FIRST, CAL_MAX);
    write_cal(IDX_SPARE_LAST, '0);
    program_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    send_reading(24'd9085466, 24'd8569150);
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(24'd9085466, raw_temperature_for(TEMP_BASE));
    send_reading(RAW_MAX, raw_temperature_for(TEMP_BASE - 1));
    pause_sender(1);
    send_reading(24'd9085466, raw_temperature_for(TEMP_COLD));
    send_reading('0, raw_temperature_for(TEMP_COLD - 1));
    drain();

    program_cal(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
    send_reading(RAW_MAX, '0);
    send_reading('0, RAW_MAX);
    send_reading(RAW_MAX, RAW_MAX);
    drain();

    program_cal(CAL_MAX, '0, CAL_MAX, '0, '0, CAL_MAX);
    send_reading(RAW_MAX, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(24'h555555, 24'hAAAAAA);
    drain();

    // Largest C5 with D2 at zero drives the temperature to its coldest value.
    program_cal('0, CAL_MAX, '0, CAL_MAX, CAL_MAX, CAL_MAX);
    send_reading(RAW_MAX, '0);
    send_reading(24'hAAAAAA, 24'h555555);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_cal(random_cal_word(), random_cal_word(), random_cal_word(),
                  random_cal_word(), random_cal_word(), random_cal_word());
      gap_odds = (phase == RANDOM_PHASES - 1) ? 0 : $urandom_range(0, 4);
      for (int n = 0; n < PHASE_READINGS; n++) begin
        case ($urandom_range(0, 7))
          0:       d1 = '0;
          1:       d1 = RAW_MAX;
          default: d1 = RAW_W'($urandom());
        endcase
        case ($urandom_range(0, 3))
          0: d2 = RAW_W'($urandom());
          1: begin
            near = longint'(sb.cal_word[REG_C5]) * 256
                   + longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            if (near < 0) near = 0;
            if (near > longint'(RAW_MAX)) near = longint'(RAW_MAX);
            d2 = near[RAW_W-1:0];
          end
          default: d2 = raw_temperature_for(int'($urandom_range(0, 7000)) - 4500);
        endcase
        send_reading(d1, d2);
        pause_sender(gap_odds);
      end
      drain();
    end

    repeat (BC_LATENCY + 4) @(posedge clk);
    if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* barometer_compensation.f */
+incdir+rtl
rtl/bc_pkg.sv
rtl/bc_front.sv
rtl/bc_queue.sv
rtl/bc_back.sv
rtl/barometer_compensation.sv
rtl/bc_checker.sv
tb/sv/barometer_compensation_test.sv
